@@ rtl/core/y2r_pkg.sv @@
package y2r_pkg;

    localparam int TAB_DEPTH = 256;
    localparam int CHROMA_BIAS = 128;
    localparam int Q_FRAC = 10;

    // Byte order codes
    typedef enum logic {
        ORDER_YUYV = 1'b0,
        ORDER_UYVY = 1'b1
    } byte_order_t;

    typedef logic signed [8:0]  off9_t;
    typedef logic signed [17:0] q10_t;
    typedef logic signed [18:0] q10_sum_t;
    typedef logic signed [9:0]  chan_t;

    typedef off9_t off9_tab_t [TAB_DEPTH];
    typedef q10_t  q10_tab_t  [TAB_DEPTH];

    // Chroma offsets shared by both pixels of a macropixel
    typedef struct packed {
        off9_t r_off;
        off9_t g_off;
        off9_t b_off;
    } chroma_off_t;

    // trunc(1.4022 * dv)
    function automatic off9_tab_t build_r_tab();
        off9_tab_t t;
        int        d;
        for (int i = 0; i < TAB_DEPTH; i++)
        begin
            d = i - CHROMA_BIAS;
            t[i] = off9_t'((7011 * d) / 5000);
        end
        return t;
    endfunction

    // trunc(1.7710 * du)
    function automatic off9_tab_t build_b_tab();
        off9_tab_t t;
        int        d;
        for (int i = 0; i < TAB_DEPTH; i++)
        begin
            d = i - CHROMA_BIAS;
            t[i] = off9_t'((1771 * d) / 1000);
        end
        return t;
    endfunction

    // Q10 green terms: trunc(1024*0.7144*dv) and trunc(1024*0.3457*du)
    function automatic q10_tab_t build_gv_tab();
        q10_tab_t t;
        int       d;
        for (int i = 0; i < TAB_DEPTH; i++)
        begin
            d = i - CHROMA_BIAS;
            t[i] = q10_t'((457216 * d) / 625);
        end
        return t;
    endfunction

    function automatic q10_tab_t build_gu_tab();
        q10_tab_t t;
        int       d;
        for (int i = 0; i < TAB_DEPTH; i++)
        begin
            d = i - CHROMA_BIAS;
            t[i] = q10_t'((221248 * d) / 625);
        end
        return t;
    endfunction

    localparam off9_tab_t R_TAB  = build_r_tab();
    localparam off9_tab_t B_TAB  = build_b_tab();
    localparam q10_tab_t  GV_TAB = build_gv_tab();
    localparam q10_tab_t  GU_TAB = build_gu_tab();

    function automatic logic [7:0] sat8(input chan_t v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 10'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

@@ rtl/core/yuv422_to_rgb_converter_core.sv @@
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     byte0..byte3 (packed macropixel)
// out       output     out_valid / out_ready   red/green/blue _first, _second
// cfg       input      cfg_valid / cfg_ready   cfg_data (byte order, 1 = UYVY)
//
// One macropixel per cycle sustained while out_ready stays high; a beat passes
// from input to output through the input register, then table lookup and
// saturation into the result register.
// rst_n clears both valid flags and sets byte order to YUYV; cfg_ready is
// always high.
// A stalled output holds its beat; the input register keeps accepting while
// the result register drains or is empty.
module yuv422_to_rgb_converter_core
    import y2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte0,
    input  logic [7:0] byte1,
    input  logic [7:0] byte2,
    input  logic [7:0] byte3,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red_first,
    output logic [7:0] green_first,
    output logic [7:0] blue_first,
    output logic [7:0] red_second,
    output logic [7:0] green_second,
    output logic [7:0] blue_second,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    byte_order_t order_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  b0_reg, b1_reg, b2_reg, b3_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  r0_reg, g0_reg, bl0_reg, r1_reg, g1_reg, bl1_reg;

    logic        out_load;
    logic        s1_load;
    logic [7:0]  y0, y1, u, v;
    q10_sum_t    g_q10;
    chroma_off_t off;
    logic [7:0]  r0, g0, bl0, r1, g1, bl1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORDER_YUYV;
        else if (cfg_valid && cfg_ready)
            order_reg <= byte_order_t'(cfg_data);
    end

    // result register takes stage 1 whenever it is empty or being drained
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_load;
    assign s1_load  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = in_valid;
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            b0_reg <= byte0;
            b1_reg <= byte1;
            b2_reg <= byte2;
            b3_reg <= byte3;
        end
    end

    always_comb
    begin
        unique case (order_reg)
            ORDER_YUYV:
            begin
                y0 = b0_reg;
                u  = b1_reg;
                y1 = b2_reg;
                v  = b3_reg;
            end
            ORDER_UYVY:
            begin
                u  = b0_reg;
                y0 = b1_reg;
                v  = b2_reg;
                y1 = b3_reg;
            end
            default:
            begin
                y0 = b0_reg;
                u  = b1_reg;
                y1 = b2_reg;
                v  = b3_reg;
            end
        endcase
    end

    // floor of the Q10 sum is its top bits
    assign g_q10     = q10_sum_t'(GV_TAB[v]) + q10_sum_t'(GU_TAB[u]);
    assign off.r_off = R_TAB[v];
    assign off.b_off = B_TAB[u];
    assign off.g_off = g_q10[18:Q_FRAC];

    y2r_pixel u_pix_first
    (
        .luma  (y0),
        .off   (off),
        .red   (r0),
        .green (g0),
        .blue  (bl0)
    );

    y2r_pixel u_pix_second
    (
        .luma  (y1),
        .off   (off),
        .red   (r1),
        .green (g1),
        .blue  (bl1)
    );

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            r0_reg  <= r0;
            g0_reg  <= g0;
            bl0_reg <= bl0;
            r1_reg  <= r1;
            g1_reg  <= g1;
            bl1_reg <= bl1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_first    = r0_reg;
    assign green_first  = g0_reg;
    assign blue_first   = bl0_reg;
    assign red_second   = r1_reg;
    assign green_second = g1_reg;
    assign blue_second  = bl1_reg;

endmodule

@@ rtl/core/y2r_pixel.sv @@
module y2r_pixel
    import y2r_pkg::*;
(
    input  logic [7:0]  luma,
    input  chroma_off_t off,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    chan_t y_ext;
    chan_t r_sum;
    chan_t g_sum;
    chan_t b_sum;

    assign y_ext = chan_t'({2'b00, luma});
    assign r_sum = y_ext + chan_t'(off.r_off);
    assign g_sum = y_ext - chan_t'(off.g_off);
    assign b_sum = y_ext + chan_t'(off.b_off);

    assign red   = sat8(r_sum);
    assign green = sat8(g_sum);
    assign blue  = sat8(b_sum);

endmodule

@@ rtl/core/y2r_checker.sv @@
module y2r_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_first,
    input logic [7:0] green_first,
    input logic [7:0] blue_first,
    input logic [7:0] red_second,
    input logic [7:0] green_second,
    input logic [7:0] blue_second
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_first)
            && $stable(green_first) && $stable(blue_first)
            && $stable(red_second) && $stable(green_second)
            && $stable(blue_second))
        else $error("output beat changed while stalled");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted beat did not reach output");

    // the reset edge itself clears the flag, so check in the cycle after reset is sampled
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind yuv422_to_rgb_converter_core y2r_checker u_y2r_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_first    (red_first),
    .green_first  (green_first),
    .blue_first   (blue_first),
    .red_second   (red_second),
    .green_second (green_second),
    .blue_second  (blue_second)
);

@@ tb/tb_top.sv @@
module tb_top
    import y2r_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_LEN = 225;
    localparam int NUM_PHASES = 6;
    localparam int NUM_DIR = 22;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } macropixel_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
    } rgb_pair_t;

    typedef struct packed {
        byte_order_t ord;
        macropixel_t mp;
        logic        pinned;
        rgb_pair_t   rgb;
    } dir_row_t;

    // Pinned rows carry a hand-derived pair; the rest go through predict_rgb
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        '{ORDER_YUYV, '{8'd0, 8'd128, 8'd0, 8'd128}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
        '{ORDER_YUYV, '{8'd255, 8'd128, 8'd255, 8'd128}, 1'b1,
          '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}},
        '{ORDER_YUYV, '{8'd128, 8'd128, 8'd128, 8'd128}, 1'b1,
          '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128}},
        '{ORDER_YUYV, '{8'd0, 8'd128, 8'd255, 8'd128}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255}},
        '{ORDER_YUYV, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd255, 8'd121, 8'd255, 8'd255, 8'd121, 8'd255}},
        '{ORDER_YUYV, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{8'd0, 8'd136, 8'd0, 8'd0, 8'd136, 8'd0}},
        '{ORDER_YUYV, '{8'd255, 8'd0, 8'd255, 8'd0}, 1'b0, '0},
        '{ORDER_YUYV, '{8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
        '{ORDER_YUYV, '{8'd0, 8'd0, 8'd255, 8'd255}, 1'b0, '0},
        '{ORDER_YUYV, '{8'd200, 8'd255, 8'd16, 8'd128}, 1'b0, '0},
        '{ORDER_YUYV, '{8'd16, 8'd128, 8'd235, 8'd255}, 1'b0, '0},
        '{ORDER_YUYV, '{8'd100, 8'd1, 8'd150, 8'd254}, 1'b0, '0},
        '{ORDER_YUYV, '{8'd127, 8'd127, 8'd128, 8'd129}, 1'b0, '0},
        '{ORDER_UYVY, '{8'd128, 8'd0, 8'd128, 8'd255}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255}},
        '{ORDER_UYVY, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{8'd0, 8'd136, 8'd0, 8'd0, 8'd136, 8'd0}},
        '{ORDER_UYVY, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd255, 8'd121, 8'd255, 8'd255, 8'd121, 8'd255}},
        '{ORDER_UYVY, '{8'd10, 8'd200, 8'd30, 8'd40}, 1'b0, '0},
        '{ORDER_UYVY, '{8'd255, 8'd0, 8'd0, 8'd255}, 1'b0, '0},
        '{ORDER_UYVY, '{8'd0, 8'd255, 8'd255, 8'd0}, 1'b0, '0},
        '{ORDER_UYVY, '{8'd129, 8'd64, 8'd127, 8'd192}, 1'b0, '0},
        '{ORDER_YUYV, '{8'd10, 8'd200, 8'd30, 8'd40}, 1'b0, '0},
        '{ORDER_YUYV, '{8'd1, 8'd254, 8'd2, 8'd253}, 1'b0, '0}
    };

    localparam byte_order_t PHASE_ORDER [NUM_PHASES] = '{
        ORDER_UYVY, ORDER_UYVY, ORDER_YUYV, ORDER_UYVY, ORDER_YUYV, ORDER_YUYV
    };
    localparam int PHASE_GAP_MAX [NUM_PHASES] = '{0, 3, 8, 1, 12, 5};

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] byte0 = 8'd0;
    logic [7:0] byte1 = 8'd0;
    logic [7:0] byte2 = 8'd0;
    logic [7:0] byte3 = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    // Expectation attached to the beat on the input port
    logic      pin_valid = 1'b0;
    rgb_pair_t pin_rgb = '0;

    rgb_pair_t   rgb_due [$];
    byte_order_t model_order = ORDER_YUYV;
    int unsigned pairs_seen = 0;
    int unsigned macropixels_sent = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_cnt = 0;
    int unsigned burst_left = 0;
    int unsigned gap_max = 2;
    int unsigned stall_left = 0;
    logic [15:0] stall_pat = '1;

    yuv422_to_rgb_converter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte0        (byte0),
        .byte1        (byte1),
        .byte2        (byte2),
        .byte3        (byte3),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_first    (red_first),
        .green_first  (green_first),
        .blue_first   (blue_first),
        .red_second   (red_second),
        .green_second (green_second),
        .blue_second  (blue_second),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [7:0] clamp_to_byte(int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic rgb_pair_t predict_rgb(byte_order_t ord, macropixel_t mp);
        rgb_pair_t px;
        int        y0;
        int        y1;
        int        du;
        int        dv;
        int        r_off;
        int        b_off;
        int        g_off;
        if (ord == ORDER_YUYV)
        begin
            y0 = int'(mp.b0);
            du = int'(mp.b1) - CHROMA_BIAS;
            y1 = int'(mp.b2);
            dv = int'(mp.b3) - CHROMA_BIAS;
        end
        else
        begin
            du = int'(mp.b0) - CHROMA_BIAS;
            y0 = int'(mp.b1);
            dv = int'(mp.b2) - CHROMA_BIAS;
            y1 = int'(mp.b3);
        end
        // Integer division truncates toward zero; the Q10 sum is floored by the shift
        r_off = (7011 * dv) / 5000;
        b_off = (1771 * du) / 1000;
        g_off = ((457216 * dv) / 625 + (221248 * du) / 625) >>> Q_FRAC;
        px.red_first    = clamp_to_byte(y0 + r_off);
        px.green_first  = clamp_to_byte(y0 - g_off);
        px.blue_first   = clamp_to_byte(y0 + b_off);
        px.red_second   = clamp_to_byte(y1 + r_off);
        px.green_second = clamp_to_byte(y1 - g_off);
        px.blue_second  = clamp_to_byte(y1 + b_off);
        return px;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd128;
            3: return 8'($urandom_range(118, 138));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic note_failure(string msg);
        if (fail_count < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
            note_failure($sformatf("pair %0d %s: expected %0d, got %0d",
                                   pairs_seen, name, want, got));
    endtask

    // Hold valid and payload until the beat is taken
    task automatic send_macropixel(macropixel_t mp, logic pinned, rgb_pair_t rgb);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        byte0     <= mp.b0;
        byte1     <= mp.b1;
        byte2     <= mp.b2;
        byte3     <= mp.b3;
        pin_valid <= pinned;
        pin_rgb   <= rgb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        macropixels_sent++;
    endtask

    // Drop valid and wait until every pair sent has come back
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pairs_seen < macropixels_sent)
            @(posedge clk);
    endtask

    task automatic write_order(byte_order_t ord);
        cfg_valid <= 1'b1;
        cfg_data  <= ord;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stalls: switch between always ready, a random mask and a sparse mask
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(40, 300);
            case ($urandom_range(0, 2))
                0: stall_pat = '1;
                1: stall_pat = 16'($urandom) | 16'h0001;
                default: stall_pat = 16'h0001 << $urandom_range(0, 15);
            endcase
        end
        stall_left--;
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        out_ready <= stall_pat[0];
    end

    always @(posedge clk)
    begin : scoreboard
        rgb_pair_t   want;
        macropixel_t mp;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                model_order = byte_order_t'(cfg_data);
            if (out_valid && out_ready)
            begin
                if (rgb_due.size() == 0)
                    note_failure($sformatf("pair %0d arrived with nothing pending",
                                           pairs_seen));
                else
                begin
                    want = rgb_due.pop_front();
                    check_chan("red_first", want.red_first, red_first);
                    check_chan("green_first", want.green_first, green_first);
                    check_chan("blue_first", want.blue_first, blue_first);
                    check_chan("red_second", want.red_second, red_second);
                    check_chan("green_second", want.green_second, green_second);
                    check_chan("blue_second", want.blue_second, blue_second);
                end
                pairs_seen <= pairs_seen + 1;
            end
            if (in_valid && in_ready)
            begin
                mp = '{byte0, byte1, byte2, byte3};
                rgb_due.push_back(pin_valid ? pin_rgb : predict_rgb(model_order, mp));
            end
        end
    end

    initial
    begin : stimulus
        byte_order_t drive_order;
        macropixel_t mp;
        drive_order = ORDER_YUYV;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows start on the reset byte order, no write before them
        for (int i = 0; i < NUM_DIR; i++)
        begin
            if (DIR_ROWS[i].ord != drive_order)
            begin
                drain();
                write_order(DIR_ROWS[i].ord);
                drive_order = DIR_ROWS[i].ord;
            end
            send_macropixel(DIR_ROWS[i].mp, DIR_ROWS[i].pinned, DIR_ROWS[i].rgb);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_order(PHASE_ORDER[p]);
            gap_max = PHASE_GAP_MAX[p];
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                mp = '{pick_byte(), pick_byte(), pick_byte(), pick_byte()};
                send_macropixel(mp, 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (rgb_due.size() != 0)
            note_failure($sformatf("%0d pairs never arrived", rgb_due.size()));
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
